// ===== rtl/core/bsort_pkg.sv =====
// Package for the sixteen-entry block sorter: state type and cell control.
package bsort_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [0:0] {
    ST_FILL  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/core/bsort_cell.sv =====
// One sorter cell: holds one element, inserts in order, shifts left on drain.
module bsort_cell (
  input  logic                                  clk_i,
  input  bsort_pkg::cell_ctl_t                  ctl_i,
  input  logic                                  occ_i,
  input  logic signed [bsort_pkg::DATA_W-1:0]   new_i,
  input  logic signed [bsort_pkg::DATA_W-1:0]   prev_val_i,
  input  logic                                  prev_lt_i,
  input  logic signed [bsort_pkg::DATA_W-1:0]   next_val_i,
  output logic signed [bsort_pkg::DATA_W-1:0]   val_o,
  output logic                                  lt_o
);

  logic signed [bsort_pkg::DATA_W-1:0] val_q, val_d;

  // new request belongs at or before this cell
  assign lt_o  = !occ_i || (new_i < val_q);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = next_val_i;
    end else if (ctl_i.ins) begin
      if (prev_lt_i) begin
        val_d = prev_val_i;
      end else if (lt_o) begin
        val_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/core/bitonic_sort_sixteen.sv =====
// Block sorter top level: insertion cell chain with fill and drain control.
//
//   channel | signals                          | handshake
//   --------+----------------------------------+---------------------------
//   request | start, value_i                   | taken when start && !busy
//   result  | strobe_o, sorted_value_o, last_o | one cycle, cannot be held
//
// A request is taken while filling and enters its sorted place in the cell
// row at once. The request that completes the block sets busy while the row
// shifts one result out per cycle, smallest first, until the last result is
// out. Reset drops a partial block.
module bitonic_sort_sixteen #(
  parameter int unsigned BLOCK_SIZE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic signed [bsort_pkg::DATA_W-1:0] value_i,
  output logic                                busy,
  output logic                                strobe_o,
  output logic signed [bsort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                                last_o
);

  localparam int unsigned CNT_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_SIZE - 1);

  bsort_pkg::state_e    state_q, state_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]     drain_q, drain_d;
  logic                 accept;
  bsort_pkg::cell_ctl_t cell_ctl;

  logic signed [bsort_pkg::DATA_W-1:0] cell_val [BLOCK_SIZE];
  logic                                cell_lt  [BLOCK_SIZE];

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bsort_pkg::ST_FILL: begin
        if (accept && (fill_q == LAST_IDX)) state_d = bsort_pkg::ST_DRAIN;
      end
      bsort_pkg::ST_DRAIN: begin
        if (drain_q == LAST_IDX) state_d = bsort_pkg::ST_FILL;
      end
      default: state_d = bsort_pkg::ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    busy           = 1'b0;
    strobe_o       = 1'b0;
    cell_ctl.ins   = 1'b0;
    cell_ctl.shift = 1'b0;
    case (state_q)
      bsort_pkg::ST_FILL: begin
        cell_ctl.ins = accept;
      end
      bsort_pkg::ST_DRAIN: begin
        busy           = 1'b1;
        strobe_o       = 1'b1;
        cell_ctl.shift = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign sorted_value_o = cell_val[0];
  assign last_o         = strobe_o && (drain_q == LAST_IDX);

  always_comb begin
    fill_d  = fill_q;
    drain_d = drain_q;
    if (accept) begin
      fill_d = (fill_q == LAST_IDX) ? '0 : fill_q + CNT_W'(1);
    end
    if (strobe_o) begin
      drain_d = (drain_q == LAST_IDX) ? '0 : drain_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsort_pkg::ST_FILL;
      fill_q  <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drain_q <= drain_d;
    end
  end

  for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
    logic signed [bsort_pkg::DATA_W-1:0] prev_val;
    logic                                prev_lt;
    logic signed [bsort_pkg::DATA_W-1:0] next_val;

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_lt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == BLOCK_SIZE - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    bsort_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .occ_i      (fill_q > CNT_W'(i)),
      .new_i      (value_i),
      .prev_val_i (prev_val),
      .prev_lt_i  (prev_lt),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .lt_o       (cell_lt[i])
    );
  end

`ifndef ASSERT_OFF
  a_block_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fill_q == LAST_IDX)) |=> strobe_o)
    else $error("completed block did not start draining");

  a_drain_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("drain stopped before last result");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> (!busy && (fill_q == '0)))
    else $error("sorter not free after last result");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> (cell_val[0] <= cell_val[1]))
    else $error("results out of order");
`endif

endmodule

// ===== verif/bitonic_sort_sixteen_tb.sv =====
// Testbench for bitonic_sort_sixteen: directed and random blocks checked against a predictor.
`timescale 1ns / 1ps

module bitonic_sort_sixteen_tb;

  localparam int unsigned BLOCK_SIZE  = 16;
  localparam int unsigned DIR_N       = 22;
  localparam int unsigned CYCLE_LIMIT = 60000;

  typedef logic signed [bsort_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  typed;
    word_t sorted_at;
  } stim_row_t;

  typedef struct packed {
    word_t sorted_value;
    logic  last;
  } sorted_item_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  word_t value_i;
  logic  busy;
  logic  strobe_o;
  word_t sorted_value_o;
  logic  last_o;

  bitonic_sort_sixteen #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .value_i       (value_i),
    .busy          (busy),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .last_o        (last_o)
  );

  stim_row_t    dir_tab [DIR_N];
  word_t        held_values [BLOCK_SIZE];
  logic         held_typed [BLOCK_SIZE];
  word_t        held_known [BLOCK_SIZE];
  word_t        lanes [BLOCK_SIZE];
  sorted_item_t sorted_expect_q [$];

  int fill_count;
  int idle_pct;
  int requests_taken;
  int results_seen;
  int blocks_done;
  int errors;
  int cycle_count;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ascending bitonic network over the block's lanes
  function automatic void sort_lanes();
    int    k;
    int    d;
    int    g;
    int    p;
    word_t tmp;
    for (k = 2; k <= BLOCK_SIZE; k = k << 1) begin
      for (d = k >> 1; d > 0; d = d >> 1) begin
        for (g = 0; g < BLOCK_SIZE; g++) begin
          p = g ^ d;
          if (p > g) begin
            if (((g & k) == 0) ? (lanes[g] > lanes[p]) : (lanes[g] < lanes[p])) begin
              tmp      = lanes[g];
              lanes[g] = lanes[p];
              lanes[p] = tmp;
            end
          end
        end
      end
    end
  endfunction

  function automatic void take_element(input word_t v, input logic typed, input word_t known);
    sorted_item_t item;
    int           i;
    held_values[fill_count] = v;
    held_typed[fill_count]  = typed;
    held_known[fill_count]  = known;
    fill_count++;
    requests_taken++;
    if (fill_count == BLOCK_SIZE) begin
      for (i = 0; i < BLOCK_SIZE; i++) lanes[i] = held_values[i];
      sort_lanes();
      for (i = 0; i < BLOCK_SIZE; i++) begin
        item.sorted_value = held_typed[i] ? held_known[i] : lanes[i];
        item.last         = (i == BLOCK_SIZE - 1);
        sorted_expect_q.push_back(item);
      end
      fill_count = 0;
      blocks_done++;
    end
  endfunction

  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(3))
      0: v = word_t'($urandom_range(6)) - 3;
      1: v = $urandom_range(1) ? (word_t'(32'h7fffffff) - word_t'($urandom_range(2)))
                               : (word_t'(32'h80000000) + word_t'($urandom_range(2)));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input word_t v, input logic typed, input word_t known);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    take_element(v, typed, known);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    sorted_item_t want;
    if (rst_ni && strobe_o) begin
      results_seen++;
      if (sorted_expect_q.size() == 0) begin
        $display("%0t: unexpected result: value %0d last %0b", $time, sorted_value_o, last_o);
        errors++;
      end else begin
        want = sorted_expect_q.pop_front();
        if (sorted_value_o !== want.sorted_value) begin
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, want.sorted_value, sorted_value_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, sorted_expect_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase_idle [3];
    int phase_items [3];
    int ph;
    int n;
    rst_ni         = 1'b0;
    start          = 1'b0;
    value_i        = '0;
    fill_count     = 0;
    idle_pct       = 0;
    requests_taken = 0;
    results_seen   = 0;
    blocks_done    = 0;
    errors         = 0;
    cycle_count    = 0;
    phase_idle     = '{25, 48, 0};
    phase_items    = '{84, 83, 83};

    // first block: extremes and duplicates, sorted order typed in
    dir_tab = '{
      '{32'sh7fffffff, 1'b1, 32'sh80000000},
      '{32'sh80000000, 1'b1, 32'sh80000000},
      '{32'sh00000000, 1'b1, 32'sh80000001},
      '{32'shffffffff, 1'b1, 32'shc0000000},
      '{32'sh00000001, 1'b1, 32'shfffffffe},
      '{32'sh7fffffff, 1'b1, 32'shffffffff},
      '{32'sh80000000, 1'b1, 32'sh00000000},
      '{32'sh00000000, 1'b1, 32'sh00000000},
      '{32'sh00000002, 1'b1, 32'sh00000001},
      '{32'shfffffffe, 1'b1, 32'sh00000002},
      '{32'sh40000000, 1'b1, 32'sh00000005},
      '{32'shc0000000, 1'b1, 32'sh00000005},
      '{32'sh00000005, 1'b1, 32'sh40000000},
      '{32'sh00000005, 1'b1, 32'sh7ffffffe},
      '{32'sh7ffffffe, 1'b1, 32'sh7fffffff},
      '{32'sh80000001, 1'b1, 32'sh7fffffff},
      // partial block, finished by the random part
      '{32'shaaaaaaaa, 1'b0, 32'sh00000000},
      '{32'sh55555555, 1'b0, 32'sh00000000},
      '{32'sh00000000, 1'b0, 32'sh00000000},
      '{32'shffffffff, 1'b0, 32'sh00000000},
      '{32'sh80000000, 1'b0, 32'sh00000000},
      '{32'sh7fffffff, 1'b0, 32'sh00000000}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_pct = phase_idle[0];
    for (n = 0; n < DIR_N; n++) begin
      send_request(dir_tab[n].value, dir_tab[n].typed, dir_tab[n].sorted_at);
    end

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      for (n = 0; n < phase_items[ph]; n++) send_request(pick_value(), 1'b0, '0);
    end
    start <= 1'b0;

    while (sorted_expect_q.size() != 0) @(posedge clk_i);
    repeat (2 * BLOCK_SIZE) @(posedge clk_i);

    $display("Sorted %0d blocks from %0d requests; %0d results checked, %0d errors.",
             blocks_done, requests_taken, results_seen, errors);
    $display("Sender idle rates 25%%, 48%% and 0%%; extremes, duplicates and partial blocks.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
